/* sv/nlm_pf_pkg.sv */
// ----------------------------------------------------------------------------
// nlm_pf_pkg
// Shared constants, register codes and the exponential weight table of the
// non-local-means pixel filter.
// ----------------------------------------------------------------------------
package nlm_pf_pkg;

  localparam int DEF_MAX_LINE_WIDTH    = 256;
  localparam int DEF_MAX_WINDOW_RADIUS = 10;
  localparam int DEF_MAX_PATCH_RADIUS  = 3;
  localparam int DEF_PIXEL_BITS        = 8;

  localparam int IN_PIX_BITS   = 8;
  localparam int FILT_BITS     = 16;
  localparam int COORD_BITS    = 8;
  localparam int OUT_DATA_BITS = FILT_BITS + 2 * COORD_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;
  localparam int INV_BITS      = 24;

  localparam int LUT_SIZE    = 2048;
  localparam int LUT_BITS    = 11;
  localparam int WEIGHT_BITS = 17;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PATCH_RADIUS     = 3'd0,
    REG_WINDOW_RADIUS    = 3'd1,
    REG_LINE_WIDTH       = 3'd2,
    REG_INV_TWO_DELTA_SQ = 3'd3,
    REG_UNBIAS_MODE      = 3'd4
  } cfg_reg_t;

  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef weight_t weight_rom_t [LUT_SIZE];

  // quotient of a dividend below 2^40, by restoring long division
  function automatic logic [63:0] div_u40(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int k = 39; k >= 0; k--) begin
      rem = {rem[63:0], a[k]};
      if (rem >= {1'b0, b}) begin
        rem = rem - {1'b0, b};
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-f/256) in Q31, alternating Taylor series
  function automatic logic [63:0] exp_q31(input logic [63:0] f);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = 64'd1 << 31;
    pos  = 64'd1 << 31;
    neg  = 64'd0;
    for (int n = 1; n <= 24; n++) begin
      term = div_u40((term * f) >> 8, 64'(n));
      if ((n & 1) != 0) neg = neg + term;
      else pos = pos + term;
    end
    return pos - neg;
  endfunction

  function automatic weight_rom_t build_weights();
    weight_rom_t rom;
    logic [63:0] e1;
    logic [63:0] v;
    e1 = exp_q31(64'd256);
    for (int i = 0; i < LUT_SIZE; i++) begin
      v = exp_q31(64'(i & 255));
      for (int k = 0; k < (i >> 8); k++) begin
        v = (v * e1 + (64'd1 << 30)) >> 31;
      end
      rom[i] = WEIGHT_BITS'((v + (64'd1 << 14)) >> 15);
    end
    return rom;
  endfunction

  localparam weight_rom_t WEIGHT_ROM = build_weights();

endpackage

/* sv/non_local_means_pixel_filter_unit.sv */
// ----------------------------------------------------------------------------
// non_local_means_pixel_filter_unit
// Streaming non-local-means filter over a mirror-padded image in raster order.
// ----------------------------------------------------------------------------
// Pixels enter one per item and are written to a line store of
// 2*MAX_WINDOW_RADIUS+1 lines. An item that does not complete a window leaves
// the unit ready for the next item. An item that completes one is filtered
// before the next item is taken; the single read port of the line store sets
// the pace: with P = 2p+1 and S = 2(w-p)+1 the centre patch of P*P pixels is
// loaded, then each of the S*S candidates' patch is read one pixel a cycle and
// its weight argument, unless past the table's end, goes through a 16-step
// divider. The finished result sits in an output register, so the next item
// is taken while it waits to be read.
// ----------------------------------------------------------------------------
module non_local_means_pixel_filter_unit
  import nlm_pf_pkg::*;
#(
  parameter int MAX_LINE_WIDTH    = DEF_MAX_LINE_WIDTH,
  parameter int MAX_WINDOW_RADIUS = DEF_MAX_WINDOW_RADIUS,
  parameter int MAX_PATCH_RADIUS  = DEF_MAX_PATCH_RADIUS,
  parameter int PIXEL_BITS        = DEF_PIXEL_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_PIX_BITS-1:0]   s_axis_tdata,   // pixel
  input  logic                     s_axis_tuser,   // frame_start
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // filtered, out_row, out_col
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int NROWS   = 2 * MAX_WINDOW_RADIUS + 1;
  localparam int DEPTH   = NROWS * MAX_LINE_WIDTH;
  localparam int AW      = $clog2(DEPTH);
  localparam int RW      = $clog2(NROWS);
  localparam int CW      = $clog2(MAX_LINE_WIDTH);
  localparam int LWW     = ($clog2(MAX_LINE_WIDTH + 1) > 9) ? $clog2(MAX_LINE_WIDTH + 1) : 9;
  localparam int WRW     = $clog2(MAX_WINDOW_RADIUS + 1);
  localparam int SPW     = $clog2(2 * MAX_WINDOW_RADIUS + 1);
  localparam int PD      = 2 * MAX_PATCH_RADIUS + 1;
  localparam int PATCH_N = PD * PD;
  localparam int PIW     = (PATCH_N > 1) ? $clog2(PATCH_N) : 1;
  localparam int NCW     = $clog2(NROWS * NROWS + 1);
  localparam int VW      = 2 * PIXEL_BITS;
  localparam int QBW     = VW + $clog2(PATCH_N + 1);
  localparam int PRW     = QBW + INV_BITS;
  localparam int NUMW    = VW + WEIGHT_BITS + NCW;
  localparam int DENW    = WEIGHT_BITS + NCW;
  localparam int DW      = (PRW > NUMW) ? PRW : NUMW;
  localparam int QW      = (VW > LUT_BITS) ? VW : LUT_BITS;
  localparam int DCW     = $clog2(QW);
  localparam int XW      = DW + QW;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_LWAIT, S_PATCH, S_VREAD, S_MUL, S_CHECK,
    S_DIV, S_LUT, S_ACC, S_FINAL, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [1:0]          cfg_p;
  logic [3:0]          cfg_wr;
  logic [8:0]          cfg_lw;
  logic [INV_BITS-1:0] cfg_inv;
  logic                cfg_unbias;

  // frame position
  logic [CW-1:0]         column_count;
  logic [COORD_BITS-1:0] row_count;
  logic [RW-1:0]         slot;
  logic [SPW-1:0]        lines_ready;

  // memories
  logic [PIXEL_BITS-1:0] store [DEPTH];
  logic [PIXEL_BITS-1:0] store_q;
  logic [PIXEL_BITS-1:0] patch_mem [PATCH_N];
  logic [PIXEL_BITS-1:0] patch_q;
  logic                  ld_pend;
  logic [PIW-1:0]        ld_idx;
  weight_t               rom_q;

  // window job
  logic [RW-1:0]         top_row;
  logic [CW-1:0]         base_col;
  logic [COORD_BITS-1:0] res_row;
  logic [COORD_BITS-1:0] res_col;
  logic [2:0]            pa;
  logic [2:0]            pb;
  logic [SPW-1:0]        ci;
  logic [SPW-1:0]        cj;
  logic                  sq_pend;
  logic [QBW-1:0]        q;
  logic [PRW-1:0]        prod;
  logic [VW-1:0]         vval;
  logic                  wgt_zero;
  logic [NUMW-1:0]       num;
  logic [DENW-1:0]       den;

  // divider
  logic [DW-1:0]   div_rem;
  logic [DENW-1:0] div_dsor;
  logic [QW-1:0]   div_quot;
  logic [DCW-1:0]  div_cnt;
  logic            div_final;

  // combinational
  logic [LWW-1:0]        lw_c;
  logic [WRW-1:0]        wr_c;
  logic [1:0]            p_c;
  logic [WRW-1:0]        s_c;
  logic [SPW-1:0]        span;
  logic [2:0]            two_p;
  logic [SPW-1:0]        two_s;
  logic [5:0]            cnt;
  logic                  accept;
  logic [CW-1:0]         eff_col;
  logic [COORD_BITS-1:0] eff_row;
  logic [RW-1:0]         eff_slot;
  logic [SPW-1:0]        eff_lr;
  logic                  produce;
  logic                  line_end;
  logic [RW:0]           top_sum;
  logic [RW-1:0]         top_next;
  logic [SPW-1:0]        rd_r;
  logic [SPW-1:0]        rd_c;
  logic [RW:0]           ring_sum;
  logic [RW-1:0]         ring;
  logic [CW-1:0]         rd_col;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [PIW-1:0]        pidx;
  logic [PIXEL_BITS-1:0] pix;
  logic [PIXEL_BITS-1:0] diff;
  logic [VW-1:0]         sq;
  logic [XW-1:0]         shifted;
  logic                  take;
  weight_t               wt;
  logic [WEIGHT_BITS+VW-1:0] wprod;
  logic [PRW-1:0]        thresh;

  always_comb begin
    if (cfg_lw < 9'd3) lw_c = LWW'(3);
    else if (32'(cfg_lw) > MAX_LINE_WIDTH) lw_c = LWW'(MAX_LINE_WIDTH);
    else lw_c = LWW'(cfg_lw);

    if (cfg_wr == 4'd0) wr_c = WRW'(1);
    else if (32'(cfg_wr) > MAX_WINDOW_RADIUS) wr_c = WRW'(MAX_WINDOW_RADIUS);
    else wr_c = WRW'(cfg_wr);

    if (32'(cfg_p) > MAX_PATCH_RADIUS) p_c = 2'(MAX_PATCH_RADIUS);
    else p_c = cfg_p;
    if (6'(p_c) > 6'(wr_c)) p_c = 2'(wr_c);

    s_c   = wr_c - WRW'(p_c);
    span  = SPW'({wr_c, 1'b0});
    two_p = {p_c, 1'b0};
    two_s = SPW'({s_c, 1'b0});
    cnt   = 6'({p_c, 1'b1}) * 6'({p_c, 1'b1});
  end

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pix           = PIXEL_BITS'(s_axis_tdata);

  always_comb begin
    eff_col  = s_axis_tuser ? '0 : column_count;
    eff_row  = s_axis_tuser ? '0 : row_count;
    eff_slot = s_axis_tuser ? '0 : slot;
    eff_lr   = s_axis_tuser ? '0 : lines_ready;
    produce  = (eff_lr >= span) && (LWW'(eff_col) >= LWW'(span));
    line_end = (LWW'(eff_col) + LWW'(1)) >= lw_c;
    top_sum  = (RW+1)'(eff_slot) + (RW+1)'(NROWS) - (RW+1)'(span);
    top_next = (top_sum >= (RW+1)'(NROWS)) ? RW'(top_sum - (RW+1)'(NROWS)) : RW'(top_sum);
    wr_addr  = AW'(eff_slot) * AW'(MAX_LINE_WIDTH) + AW'(eff_col);
  end

  always_comb begin
    case (state)
      S_LOAD: begin
        rd_r = SPW'(s_c) + SPW'(pa);
        rd_c = SPW'(s_c) + SPW'(pb);
      end
      S_PATCH: begin
        rd_r = ci + SPW'(pa);
        rd_c = cj + SPW'(pb);
      end
      default: begin
        rd_r = ci + SPW'(p_c);
        rd_c = cj + SPW'(p_c);
      end
    endcase
    ring_sum = (RW+1)'(top_row) + (RW+1)'(rd_r);
    ring     = (ring_sum >= (RW+1)'(NROWS)) ? RW'(ring_sum - (RW+1)'(NROWS)) : RW'(ring_sum);
    rd_col   = base_col + CW'(rd_c);
    rd_addr  = AW'(ring) * AW'(MAX_LINE_WIDTH) + AW'(rd_col);
    pidx     = PIW'(pa) * PIW'(PD) + PIW'(pb);
  end

  always_comb begin
    diff    = (store_q > patch_q) ? store_q - patch_q : patch_q - store_q;
    sq      = VW'(diff) * VW'(diff);
    shifted = XW'(div_dsor) << div_cnt;
    take    = XW'(div_rem) >= shifted;
    wt      = wgt_zero ? '0 : rom_q;
    wprod   = wt * vval;
    thresh  = PRW'(cnt) << (LUT_BITS + 8);
  end

  // line store and centre patch store
  always_ff @(posedge clk) begin
    if (accept) store[wr_addr] <= pix;
    store_q <= store[rd_addr];
    if (ld_pend) patch_mem[ld_idx] <= store_q;
    patch_q <= patch_mem[pidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_p      <= 2'd3;
      cfg_wr     <= 4'd10;
      cfg_lw     <= 9'd256;
      cfg_inv    <= 24'd65536;
      cfg_unbias <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_PATCH_RADIUS:     cfg_p      <= cfg_wdata[1:0];
        REG_WINDOW_RADIUS:    cfg_wr     <= cfg_wdata[3:0];
        REG_LINE_WIDTH:       cfg_lw     <= cfg_wdata[8:0];
        REG_INV_TWO_DELTA_SQ: cfg_inv    <= cfg_wdata[INV_BITS-1:0];
        REG_UNBIAS_MODE:      cfg_unbias <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      column_count  <= '0;
      row_count     <= '0;
      slot          <= '0;
      lines_ready   <= '0;
      ld_pend       <= 1'b0;
      sq_pend       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready && state != S_DONE) m_axis_tvalid <= 1'b0;
      ld_pend <= (state == S_LOAD);
      sq_pend <= (state == S_PATCH);
      if (sq_pend) q <= q + QBW'(sq);

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (line_end) begin
              column_count <= '0;
              row_count    <= eff_row + COORD_BITS'(1);
              slot         <= (eff_slot == RW'(NROWS - 1)) ? '0 : eff_slot + RW'(1);
              lines_ready  <= (32'(eff_lr) < 2 * MAX_WINDOW_RADIUS) ?
                              eff_lr + SPW'(1) : eff_lr;
            end else begin
              column_count <= eff_col + CW'(1);
              row_count    <= eff_row;
              slot         <= eff_slot;
              lines_ready  <= eff_lr;
            end
            if (produce) begin
              top_row  <= top_next;
              base_col <= eff_col - CW'(span);
              res_row  <= eff_row - COORD_BITS'(span);
              res_col  <= COORD_BITS'(eff_col - CW'(span));
              pa       <= '0;
              pb       <= '0;
              ci       <= '0;
              cj       <= '0;
              num      <= '0;
              den      <= '0;
              state    <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          ld_idx  <= pidx;
          if (pb == two_p) begin
            pb <= '0;
            if (pa == two_p) begin
              pa    <= '0;
              state <= S_LWAIT;
            end else begin
              pa <= pa + 3'd1;
            end
          end else begin
            pb <= pb + 3'd1;
          end
        end
        S_LWAIT: begin
          q     <= '0;
          state <= S_PATCH;
        end
        S_PATCH: begin
          if (pb == two_p) begin
            pb <= '0;
            if (pa == two_p) begin
              pa    <= '0;
              state <= S_VREAD;
            end else begin
              pa <= pa + 3'd1;
            end
          end else begin
            pb <= pb + 3'd1;
          end
        end
        S_VREAD: begin
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= q * cfg_inv;
          vval  <= cfg_unbias ? VW'(store_q) * VW'(store_q) : VW'(store_q);
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (prod >= thresh) begin
            wgt_zero <= 1'b1;
            state    <= S_ACC;
          end else begin
            wgt_zero  <= 1'b0;
            div_rem   <= DW'(prod);
            div_dsor  <= DENW'({cnt, 8'd0});
            div_quot  <= '0;
            div_cnt   <= DCW'(QW - 1);
            div_final <= 1'b0;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (take) begin
            div_rem           <= div_rem - DW'(shifted);
            div_quot[div_cnt] <= 1'b1;
          end
          if (div_cnt == '0) begin
            state <= div_final ? S_DONE : S_LUT;
          end else begin
            div_cnt <= div_cnt - DCW'(1);
          end
        end
        S_LUT: begin
          rom_q <= WEIGHT_ROM[div_quot[LUT_BITS-1:0]];
          state <= S_ACC;
        end
        S_ACC: begin
          den <= den + DENW'(wt);
          num <= num + NUMW'(wprod);
          q   <= '0;
          if (cj == two_s) begin
            cj <= '0;
            if (ci == two_s) begin
              state <= S_FINAL;
            end else begin
              ci    <= ci + SPW'(1);
              state <= S_PATCH;
            end
          end else begin
            cj    <= cj + SPW'(1);
            state <= S_PATCH;
          end
        end
        S_FINAL: begin
          if (den == '0) begin
            div_quot <= '0;
            state    <= S_DONE;
          end else begin
            div_rem   <= DW'(num);
            div_dsor  <= den;
            div_quot  <= '0;
            div_cnt   <= DCW'(QW - 1);
            div_final <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {res_col, res_row, FILT_BITS'(div_quot)};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
